// ----- rtl/bsfc_pkg.sv -----
`timescale 1ns / 1ps

package bsfc_pkg;

    // Fixed-point layout
    localparam int STATE_FRAC_BITS = 12;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int PROD_FRAC_BITS  = STATE_FRAC_BITS + GAIN_FRAC_BITS;

    localparam int STATE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = STATE_W + 1;
    localparam int DOT_W    = GAIN_W + ERR_W + 1;
    localparam int SUM_W    = DOT_W + 2;
    localparam int TORQUE_W = 15;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int THR_W    = 15;
    localparam int CNT_W    = 16;

    localparam int SPIN_LIMIT  = 10;
    localparam int WHEEL_LIMIT = 50;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(262);
    localparam logic [CNT_W-1:0] SETTLE_RESET    = CNT_W'(100);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_STAND_TILT  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_STAND_DRIVE = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_STAND_SPIN  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BAL_TILT    = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_BAL_DRIVE   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_BAL_SPIN    = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_THRESHOLD   = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_SETTLE      = IDX_W'(7);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STAND   = 2'd1,
        MODE_BALANCE = 2'd2
    } mode_t;

    // One gain set: each word is {rate gain, position gain}, signed Q8.8 halves
    typedef struct packed {
        logic [CFG_W-1:0] tilt;
        logic [CFG_W-1:0] drive;
        logic [CFG_W-1:0] spin;
    } gain_set_t;

    typedef struct packed {
        logic signed [STATE_W-1:0] tilt_angle;
        logic signed [STATE_W-1:0] tilt_rate;
        logic signed [ERR_W-1:0]   drive_err;
        logic signed [STATE_W-1:0] drive_velocity;
        logic signed [ERR_W-1:0]   spin_err;
        logic signed [STATE_W-1:0] spin_velocity;
    } err_vec_t;

endpackage

// ----- rtl/bsfc_torque.sv -----
`timescale 1ns / 1ps

module bsfc_torque (
    input  bsfc_pkg::gain_set_t                    gains,
    input  bsfc_pkg::err_vec_t                     errs,
    output logic signed [bsfc_pkg::TORQUE_W-1:0]   left_torque,
    output logic signed [bsfc_pkg::TORQUE_W-1:0]   right_torque
);

    localparam int DW = bsfc_pkg::DOT_W;
    localparam int SW = bsfc_pkg::SUM_W;
    localparam int EW = bsfc_pkg::ERR_W;
    localparam int GW = bsfc_pkg::GAIN_W;

    localparam logic signed [SW-1:0] SPIN_LIM =
        SW'(bsfc_pkg::SPIN_LIMIT) <<< bsfc_pkg::PROD_FRAC_BITS;
    localparam logic signed [SW-1:0] WHEEL_LIM =
        SW'(bsfc_pkg::WHEEL_LIMIT) <<< bsfc_pkg::PROD_FRAC_BITS;
    localparam logic signed [SW-1:0] HALF_LSB =
        SW'(1) <<< (bsfc_pkg::STATE_FRAC_BITS - 1);

    function automatic logic signed [DW-1:0] dot2(
        input logic [bsfc_pkg::CFG_W-1:0] g,
        input logic signed [EW-1:0]       e_pos,
        input logic signed [EW-1:0]       e_rate
    );
        logic signed [GW-1:0] k0;
        logic signed [GW-1:0] k1;
        logic signed [DW-1:0] p0;
        logic signed [DW-1:0] p1;
        k0 = $signed(g[GW-1:0]);
        k1 = $signed(g[2*GW-1:GW]);
        p0 = DW'(k0) * DW'(e_pos);
        p1 = DW'(k1) * DW'(e_rate);
        return p0 + p1;
    endfunction

    function automatic logic signed [SW-1:0] clamp(
        input logic signed [SW-1:0] v,
        input logic signed [SW-1:0] lim
    );
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    logic signed [SW-1:0] u_tilt;
    logic signed [SW-1:0] u_drive;
    logic signed [SW-1:0] u_spin;
    logic signed [SW-1:0] left_sum;
    logic signed [SW-1:0] right_sum;
    logic signed [SW-1:0] left_rnd;
    logic signed [SW-1:0] right_rnd;

    always_comb begin
        u_tilt  = SW'(dot2(gains.tilt, EW'(errs.tilt_angle), EW'(errs.tilt_rate)));
        u_drive = SW'(dot2(gains.drive, errs.drive_err, EW'(errs.drive_velocity)));
        u_spin  = clamp(SW'(dot2(gains.spin, errs.spin_err, EW'(errs.spin_velocity))),
                        SPIN_LIM);
        left_sum  = clamp(u_tilt + u_drive + u_spin, WHEEL_LIM);
        right_sum = clamp(u_tilt + u_drive - u_spin, WHEEL_LIM);
        // round half up, then drop the state fraction bits
        left_rnd  = (left_sum + HALF_LSB) >>> bsfc_pkg::STATE_FRAC_BITS;
        right_rnd = (right_sum + HALF_LSB) >>> bsfc_pkg::STATE_FRAC_BITS;
        left_torque  = left_rnd[bsfc_pkg::TORQUE_W-1:0];
        right_torque = right_rnd[bsfc_pkg::TORQUE_W-1:0];
    end

endmodule

// ----- rtl/balance_state_feedback_controller_core.sv -----
`timescale 1ns / 1ps
// Path: an accepted request sits in the input register, then moves to the result register.
// Throughput: one request per cycle unless m_ready holds a result; the six multiply-adds and clamps sit in one
//   combinational pass between the input register and the result register.
// Reset (aresetn, synchronous, active low): pipeline empty, mode stand, tick count
//   and reference positions zero, gains zero, threshold 262, settle limit 100.

module balance_state_feedback_controller_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [bsfc_pkg::IDX_W-1:0]            cfg_index,
    input  logic [bsfc_pkg::CFG_W-1:0]            cfg_wdata,
    // input request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [bsfc_pkg::STATE_W-1:0]   s_tilt_angle,
    input  logic signed [bsfc_pkg::STATE_W-1:0]   s_tilt_rate,
    input  logic signed [bsfc_pkg::STATE_W-1:0]   s_drive_position,
    input  logic signed [bsfc_pkg::STATE_W-1:0]   s_drive_velocity,
    input  logic signed [bsfc_pkg::STATE_W-1:0]   s_spin_position,
    input  logic signed [bsfc_pkg::STATE_W-1:0]   s_spin_velocity,
    input  logic                                  s_wake,
    input  logic                                  s_enable,
    // result request channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bsfc_pkg::TORQUE_W-1:0]  m_left_torque,
    output logic signed [bsfc_pkg::TORQUE_W-1:0]  m_right_torque,
    output logic [1:0]                            m_mode_now
);

    localparam int SW = bsfc_pkg::STATE_W;
    localparam int TW = bsfc_pkg::TORQUE_W;

    // ---------------- configuration registers ----------------
    bsfc_pkg::gain_set_t              stand_gains_reg;
    bsfc_pkg::gain_set_t              bal_gains_reg;
    logic [bsfc_pkg::THR_W-1:0]       threshold_reg;
    logic [bsfc_pkg::CNT_W-1:0]       settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stand_gains_reg <= '0;
            bal_gains_reg   <= '0;
            threshold_reg   <= bsfc_pkg::THRESHOLD_RESET;
            settle_reg      <= bsfc_pkg::SETTLE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bsfc_pkg::REG_STAND_TILT:  stand_gains_reg.tilt  <= cfg_wdata;
                bsfc_pkg::REG_STAND_DRIVE: stand_gains_reg.drive <= cfg_wdata;
                bsfc_pkg::REG_STAND_SPIN:  stand_gains_reg.spin  <= cfg_wdata;
                bsfc_pkg::REG_BAL_TILT:    bal_gains_reg.tilt    <= cfg_wdata;
                bsfc_pkg::REG_BAL_DRIVE:   bal_gains_reg.drive   <= cfg_wdata;
                bsfc_pkg::REG_BAL_SPIN:    bal_gains_reg.spin    <= cfg_wdata;
                bsfc_pkg::REG_THRESHOLD:   threshold_reg <= cfg_wdata[bsfc_pkg::THR_W-1:0];
                bsfc_pkg::REG_SETTLE:      settle_reg    <= cfg_wdata[bsfc_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // in_valid_reg: a request sits in the input register.
    // advance: it moves to the result register (and updates mode state) this cycle.
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input register payload, no reset needed
    logic signed [SW-1:0] tilt_reg;
    logic signed [SW-1:0] rate_reg;
    logic signed [SW-1:0] dpos_reg;
    logic signed [SW-1:0] dvel_reg;
    logic signed [SW-1:0] spos_reg;
    logic signed [SW-1:0] svel_reg;
    logic                 wake_reg;
    logic                 enable_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tilt_reg   <= s_tilt_angle;
            rate_reg   <= s_tilt_rate;
            dpos_reg   <= s_drive_position;
            dvel_reg   <= s_drive_velocity;
            spos_reg   <= s_spin_position;
            svel_reg   <= s_spin_velocity;
            wake_reg   <= s_wake;
            enable_reg <= s_enable;
        end
    end

    // ---------------- mode state ----------------
    bsfc_pkg::mode_t              mode_reg, mode_next;
    logic [bsfc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic signed [SW-1:0]         ref_drive_reg, ref_drive_next;
    logic signed [SW-1:0]         ref_spin_reg, ref_spin_next;

    logic [SW:0]                  tilt_mag;    // one bit more so |-32768| fits
    logic [bsfc_pkg::CNT_W-1:0]   count_inc;
    logic                         balanced;

    assign tilt_mag = tilt_reg[SW-1] ? (SW+1)'(-(SW+1)'(tilt_reg)) : (SW+1)'(tilt_reg);
    assign balanced = tilt_mag < (SW+1)'(threshold_reg);

    // next state: wake transition first, then the stand settle check sees the
    // mode it produced (a stand entered this tick is checked in the same tick)
    always_comb begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        ref_drive_next = ref_drive_reg;
        ref_spin_next  = ref_spin_reg;
        count_inc      = count_reg;
        case (mode_reg)
            bsfc_pkg::MODE_IDLE: begin
                if (wake_reg) begin
                    mode_next      = bsfc_pkg::MODE_STAND;
                    ref_drive_next = dpos_reg;
                    ref_spin_next  = spos_reg;
                end
            end
            default: ;
        endcase
        case (mode_next)
            bsfc_pkg::MODE_STAND: begin
                // count saturates at all ones
                if (balanced && (count_reg != '1)) begin
                    count_inc = count_reg + 1'b1;
                end
                count_next = count_inc;
                if (count_inc > settle_reg) begin
                    mode_next      = bsfc_pkg::MODE_BALANCE;
                    count_next     = '0;
                    ref_drive_next = dpos_reg;
                    ref_spin_next  = spos_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= bsfc_pkg::MODE_STAND;
            count_reg     <= '0;
            ref_drive_reg <= '0;
            ref_spin_reg  <= '0;
        end else if (advance) begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            ref_drive_reg <= ref_drive_next;
            ref_spin_reg  <= ref_spin_next;
        end
    end

    // outputs of the mode logic: gain set and torque gate follow the new mode;
    // the unused code behaves like idle
    bsfc_pkg::gain_set_t gain_sel;
    logic                drive_on;

    always_comb begin
        case (mode_next)
            bsfc_pkg::MODE_STAND: begin
                gain_sel = stand_gains_reg;
                drive_on = enable_reg;
            end
            bsfc_pkg::MODE_BALANCE: begin
                gain_sel = bal_gains_reg;
                drive_on = enable_reg;
            end
            default: begin
                gain_sel = stand_gains_reg;
                drive_on = 1'b0;
            end
        endcase
    end

    // ---------------- torque datapath ----------------
    bsfc_pkg::err_vec_t   errs;
    logic signed [TW-1:0] left_calc;
    logic signed [TW-1:0] right_calc;

    always_comb begin
        errs.tilt_angle     = tilt_reg;
        errs.tilt_rate      = rate_reg;
        errs.drive_err      = (SW+1)'(dpos_reg) - (SW+1)'(ref_drive_next);
        errs.drive_velocity = dvel_reg;
        errs.spin_err       = (SW+1)'(spos_reg) - (SW+1)'(ref_spin_next);
        errs.spin_velocity  = svel_reg;
    end

    bsfc_torque u_torque (
        .gains        (gain_sel),
        .errs         (errs),
        .left_torque  (left_calc),
        .right_torque (right_calc)
    );

    // result register payload
    logic signed [TW-1:0] left_reg;
    logic signed [TW-1:0] right_reg;
    bsfc_pkg::mode_t      mode_out_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            left_reg     <= drive_on ? left_calc : '0;
            right_reg    <= drive_on ? right_calc : '0;
            mode_out_reg <= mode_next;
        end
    end

    assign m_left_torque  = left_reg;
    assign m_right_torque = right_reg;
    assign m_mode_now     = mode_out_reg;

`ifndef ASSERT_OFF
    localparam logic signed [TW-1:0] TORQUE_MAX =
        TW'(bsfc_pkg::WHEEL_LIMIT << bsfc_pkg::GAIN_FRAC_BITS);

    // balance clears the count and nothing counts afterwards
    a_bal_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == bsfc_pkg::MODE_BALANCE |-> count_reg == '0)
        else $error("tick count nonzero in balance");

    // references stay put while balancing
    a_bal_ref_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == bsfc_pkg::MODE_BALANCE) && ($past(mode_reg) == bsfc_pkg::MODE_BALANCE)
        |-> $stable(ref_drive_reg) && $stable(ref_spin_reg))
        else $error("reference moved during balance");

    // idle results carry no torque
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_mode_now == bsfc_pkg::MODE_IDLE)
        |-> (m_left_torque == '0) && (m_right_torque == '0))
        else $error("torque in idle");

    // wheel clamp holds on delivered results
    a_torque_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_torque <= TORQUE_MAX) && (m_left_torque >= -TORQUE_MAX)
                 && (m_right_torque <= TORQUE_MAX) && (m_right_torque >= -TORQUE_MAX))
        else $error("wheel torque out of range");

    // a request that moves forward always lands in the result register
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced request lost");
`endif

endmodule

// ----- verif/balance_state_feedback_controller_core_tb.sv -----
`timescale 1ns / 1ps

module balance_state_feedback_controller_core_tb;
    import bsfc_pkg::*;

    // Cycles with no request moving on either side before the run is called hung.
    // Worst quiet stretch is the long result hold-off plus config gaps.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_AT     = 400;   // results seen before the long hold-off
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        logic signed [STATE_W-1:0] tilt;
        logic signed [STATE_W-1:0] rate;
        logic signed [STATE_W-1:0] dpos;
        logic signed [STATE_W-1:0] dvel;
        logic signed [STATE_W-1:0] spos;
        logic signed [STATE_W-1:0] svel;
        logic                      wake;
        logic                      enable;
    } tick_t;

    typedef struct {
        logic signed [TORQUE_W-1:0] left;
        logic signed [TORQUE_W-1:0] right;
        mode_t                      mode;
    } torque_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                       cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]           cfg_index = '0;
    logic [CFG_W-1:0]           cfg_wdata = '0;

    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [STATE_W-1:0]  s_tilt_angle = '0;
    logic signed [STATE_W-1:0]  s_tilt_rate = '0;
    logic signed [STATE_W-1:0]  s_drive_position = '0;
    logic signed [STATE_W-1:0]  s_drive_velocity = '0;
    logic signed [STATE_W-1:0]  s_spin_position = '0;
    logic signed [STATE_W-1:0]  s_spin_velocity = '0;
    logic                       s_wake = 1'b0;
    logic                       s_enable = 1'b0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [TORQUE_W-1:0] m_left_torque;
    logic signed [TORQUE_W-1:0] m_right_torque;
    logic [1:0]                 m_mode_now;

    balance_state_feedback_controller_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_tilt_angle     (s_tilt_angle),
        .s_tilt_rate      (s_tilt_rate),
        .s_drive_position (s_drive_position),
        .s_drive_velocity (s_drive_velocity),
        .s_spin_position  (s_spin_position),
        .s_spin_velocity  (s_spin_velocity),
        .s_wake           (s_wake),
        .s_enable         (s_enable),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_torque    (m_left_torque),
        .m_right_torque   (m_right_torque),
        .m_mode_now       (m_mode_now)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller shadow: config copy and mode/count/reference state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] gains [6];
    int               thr_cfg;
    int               settle_cfg;
    mode_t            ctl_mode;
    int               tick_count;
    int               ref_dpos;
    int               ref_spos;

    tick_t   ticks_to_send [$];   // requests waiting for the driver
    torque_t results_due [$];     // predicted results, oldest first
    tick_t   on_wire;             // request currently offered on the s_ side

    int errors = 0;
    int results_seen = 0;
    bit calm = 1'b0;              // no idling on either side once set

    // two signed Q8.8 gains {rate, pos} against two errors, exact
    function automatic longint gain_dot(logic [CFG_W-1:0] g, longint e_pos, longint e_rate);
        longint k_pos;
        longint k_rate;
        k_pos  = longint'($signed(g[GAIN_W-1:0]));
        k_rate = longint'($signed(g[CFG_W-1:GAIN_W]));
        return k_pos * e_pos + k_rate * e_rate;
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // drop STATE_FRAC_BITS, round half toward +inf
    function automatic logic signed [TORQUE_W-1:0] round_torque(longint v);
        return TORQUE_W'((v + (longint'(1) <<< (STATE_FRAC_BITS - 1))) >>> STATE_FRAC_BITS);
    endfunction

    // One control tick: update mode/count/refs, then work out the torques.
    function automatic torque_t advance_controller(tick_t t);
        torque_t r;
        int      mag;
        int      base;
        longint  ut;
        longint  ux;
        longint  us;
        r.left  = '0;
        r.right = '0;
        if (ctl_mode == MODE_IDLE && t.wake) begin
            ctl_mode = MODE_STAND;
            ref_dpos = int'(t.dpos);
            ref_spos = int'(t.spos);
        end
        if (ctl_mode == MODE_STAND) begin
            mag = (t.tilt < 0) ? -int'(t.tilt) : int'(t.tilt);
            if (mag < thr_cfg && tick_count < 65535)
                tick_count++;
            if (tick_count > settle_cfg) begin
                ctl_mode   = MODE_BALANCE;
                tick_count = 0;
                ref_dpos   = int'(t.dpos);
                ref_spos   = int'(t.spos);
            end
        end
        if ((ctl_mode == MODE_STAND || ctl_mode == MODE_BALANCE) && t.enable) begin
            base = (ctl_mode == MODE_STAND) ? int'(REG_STAND_TILT) : int'(REG_BAL_TILT);
            ut = gain_dot(gains[base], t.tilt, t.rate);
            ux = gain_dot(gains[base + 1], longint'(t.dpos) - ref_dpos, t.dvel);
            us = clamp_mag(gain_dot(gains[base + 2], longint'(t.spos) - ref_spos, t.svel),
                           longint'(SPIN_LIMIT) <<< PROD_FRAC_BITS);
            r.left  = round_torque(clamp_mag(ut + ux + us,
                                             longint'(WHEEL_LIMIT) <<< PROD_FRAC_BITS));
            r.right = round_torque(clamp_mag(ut + ux - us,
                                             longint'(WHEEL_LIMIT) <<< PROD_FRAC_BITS));
        end
        r.mode = ctl_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    function automatic tick_t make_tick(int tilt, int rate, int dpos, int dvel,
                                        int spos, int svel, bit wake, bit enable);
        tick_t t;
        t.tilt   = STATE_W'(tilt);
        t.rate   = STATE_W'(rate);
        t.dpos   = STATE_W'(dpos);
        t.dvel   = STATE_W'(dvel);
        t.spos   = STATE_W'(spos);
        t.svel   = STATE_W'(svel);
        t.wake   = wake;
        t.enable = enable;
        return t;
    endfunction

    // mix of near-zero, rail and full-range state values
    function automatic logic signed [STATE_W-1:0] rand_state();
        case ($urandom_range(0, 3))
            0: return STATE_W'(int'($urandom_range(0, 1024)) - 512);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return STATE_W'($urandom);
        endcase
    endfunction

    // half the time tilt sits inside +-span so the settle count moves
    function automatic tick_t rand_tick(int span);
        tick_t t;
        if ($urandom_range(0, 1))
            t.tilt = STATE_W'(int'($urandom_range(0, 2 * span)) - span);
        else
            t.tilt = rand_state();
        t.rate   = rand_state();
        t.dpos   = rand_state();
        t.dvel   = rand_state();
        t.spos   = rand_state();
        t.svel   = rand_state();
        t.wake   = $urandom_range(0, 1);
        t.enable = ($urandom_range(0, 7) != 0);
        return t;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain_half();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return GAIN_W'(int'($urandom_range(0, 1200)) - 600);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Config writes and phase sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_THRESHOLD: thr_cfg = int'(val[THR_W-1:0]);
            REG_SETTLE:    settle_cfg = int'(val[CNT_W-1:0]);
            default:       gains[idx] = val;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_random_gains(logic [IDX_W-1:0] first);
        write_reg(first,             {rand_gain_half(), rand_gain_half()});
        write_reg(IDX_W'(first + 1), {rand_gain_half(), rand_gain_half()});
        write_reg(IDX_W'(first + 2), {rand_gain_half(), rand_gain_half()});
    endtask

    // nothing queued, nothing offered, nothing owed; then cover the input and result registers
    task automatic wait_drained();
        @(negedge aclk);
        while (ticks_to_send.size() != 0 || s_valid || results_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_random(int count, int span);
        @(negedge aclk);
        repeat (count) ticks_to_send.push_back(rand_tick(span));
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued requests, predicts on accept
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready)
                results_due.push_back(advance_controller(on_wire));
            // slot is free after this edge: idle, or put up the next request
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (ticks_to_send.size() > 0) begin
                    on_wire = ticks_to_send.pop_front();
                    s_tilt_angle     <= on_wire.tilt;
                    s_tilt_rate      <= on_wire.rate;
                    s_drive_position <= on_wire.dpos;
                    s_drive_velocity <= on_wire.dvel;
                    s_spin_position  <= on_wire.spos;
                    s_spin_velocity  <= on_wire.svel;
                    s_wake           <= on_wire.wake;
                    s_enable         <= on_wire.enable;
                    s_valid          <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stalls, one long hold-off to back up the pipe
    // ------------------------------------------------------------------
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    torque_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result: left %0d right %0d mode %0d",
                             $time, m_left_torque, m_right_torque, m_mode_now);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (m_left_torque !== want.left) begin
                        $display("%0t: left_torque expected %0d got %0d",
                                 $time, want.left, m_left_torque);
                        errors++;
                    end
                    if (m_right_torque !== want.right) begin
                        $display("%0t: right_torque expected %0d got %0d",
                                 $time, want.right, m_right_torque);
                        errors++;
                    end
                    if (m_mode_now !== want.mode) begin
                        $display("%0t: mode_now expected %0d got %0d",
                                 $time, want.mode, m_mode_now);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                // sender keeps going; block fills and drops s_ready
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no request moving for too long
    // ------------------------------------------------------------------
    int quiet = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("balance_state_feedback_controller_core_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 6; i++)
            gains[i] = '0;
        thr_cfg    = int'(THRESHOLD_RESET);
        settle_cfg = int'(SETTLE_RESET);
        ctl_mode   = MODE_STAND;
        tick_count = 0;
        ref_dpos   = 0;
        ref_spos   = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: zero gains, so torques are zero whatever the state
        @(negedge aclk);
        ticks_to_send.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 1));
        ticks_to_send.push_back(make_tick(32767, 32767, 32767, 32767, 32767, 32767, 1, 1));
        ticks_to_send.push_back(make_tick(-32768, -32768, -32768, -32768, -32768, -32768, 0, 1));
        ticks_to_send.push_back(make_tick(261, 0, 0, 0, 0, 0, 1, 0));
        wait_drained();

        // unit tilt gain, full spin gain: rounding and spin clamp
        write_reg(REG_STAND_TILT,  32'h0000_0001);
        write_reg(REG_STAND_DRIVE, 32'h0000_0000);
        write_reg(REG_STAND_SPIN,  32'h0000_7FFF);
        @(negedge aclk);
        ticks_to_send.push_back(make_tick(2048, 0, 0, 0, 0, 0, 0, 1));    // +0.5 lsb -> up
        ticks_to_send.push_back(make_tick(-2048, 0, 0, 0, 0, 0, 0, 1));   // -0.5 lsb -> 0
        ticks_to_send.push_back(make_tick(-2049, 0, 0, 0, 0, 0, 1, 1));
        ticks_to_send.push_back(make_tick(0, 0, 0, 0, 32767, 0, 0, 1));   // spin at +10
        ticks_to_send.push_back(make_tick(0, 0, 0, 0, -32768, 0, 1, 1));  // spin at -10
        ticks_to_send.push_back(make_tick(2048, 0, 0, 0, 32767, 0, 0, 0)); // disabled
        ticks_to_send.push_back(make_tick(262, 0, 0, 0, 0, 0, 0, 1));     // threshold edge
        ticks_to_send.push_back(make_tick(-262, 0, 0, 0, 0, 0, 0, 1));
        ticks_to_send.push_back(make_tick(-261, 0, 0, 0, 0, 0, 0, 1));
        wait_drained();

        // rail gains: wheel clamp both ways, extreme drive terms
        write_reg(REG_STAND_TILT,  32'h7FFF_7FFF);
        write_reg(REG_STAND_DRIVE, 32'h8000_8000);
        write_reg(REG_STAND_SPIN,  32'h8000_7FFF);
        @(negedge aclk);
        ticks_to_send.push_back(make_tick(32767, 32767, 0, 0, 0, 0, 0, 1));
        ticks_to_send.push_back(make_tick(-32768, -32768, 0, 0, 0, 0, 1, 1));
        ticks_to_send.push_back(make_tick(0, 0, 32767, -32768, 0, 0, 0, 1));
        ticks_to_send.push_back(make_tick(0, 0, -32768, 32767, 32767, -32768, 1, 1));
        ticks_to_send.push_back(make_tick(1, -1, 1, -1, -1, 32767, 0, 1));
        wait_drained();

        // long stand stretch; settle limit at max keeps the mode parked
        write_reg(REG_SETTLE, 32'h0000_FFFF);
        write_reg(REG_THRESHOLD, 32'h0000_7FFF);
        load_random_gains(REG_STAND_TILT);
        send_random(250, 32767);

        write_reg(REG_THRESHOLD, 32'h0000_0000);
        load_random_gains(REG_STAND_TILT);
        send_random(150, 32767);

        repeat (2) begin
            write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 32767)));
            load_random_gains(REG_STAND_TILT);
            send_random(100, 4000);
        end

        // arm balance entry a couple dozen balanced ticks out
        write_reg(REG_THRESHOLD, CFG_W'(1500));
        write_reg(REG_SETTLE, CFG_W'(tick_count + 25));
        load_random_gains(REG_BAL_TILT);
        send_random(250, 1500);

        // balance: threshold and settle no longer matter but are still written
        write_reg(REG_SETTLE, 32'h0000_0000);
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 32767)));
            write_reg(REG_SETTLE, CFG_W'($urandom_range(0, 65535)));
            load_random_gains(REG_BAL_TILT);
            load_random_gains(REG_STAND_TILT);
            send_random(120, 2000);
        end

        write_reg(REG_BAL_TILT,  32'h8000_8000);
        write_reg(REG_BAL_DRIVE, 32'h7FFF_7FFF);
        write_reg(REG_BAL_SPIN,  32'h8000_8000);
        send_random(80, 32767);

        // closing stretch at full rate, no idling either side
        calm = 1'b1;
        load_random_gains(REG_BAL_TILT);
        send_random(120, 32767);

        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("balance_state_feedback_controller_core_tb: clean");
        else
            $display("balance_state_feedback_controller_core_tb: errors");
        $finish;
    end

endmodule
